// File: hw/rtl/sfd_pkg.sv
// Shared constants for the sensor frame deframer: frame markers, word layout,
// status codes and the default frame length. No dependencies.
package sfd_pkg;

    // Frame length default, in bytes, counting the start byte
    localparam int FRAME_BYTES_DEF = 32;

    // Frame markers
    localparam logic [7:0] START_BYTE   = 8'h42;
    localparam logic [7:0] SECOND_MAGIC = 8'h4d;

    // Measurement word layout
    localparam int WORD_COUNT        = 12;
    localparam int FIRST_WORD_OFFSET = 4;
    localparam int LEN_OVERHEAD      = 4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_SUM   = 2'd3;

endpackage

// File: hw/rtl/sfd_frame_ram.sv
// Frame byte store: one write port, one read port with registered read data.
// Depends on nothing; depth comes from the top level.
module sfd_frame_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sensor_frame_deframer.sv
// Sensor frame deframer top level: collection, check sequencer, output register.
// Depends on sfd_pkg and sfd_frame_ram.
//
// Usage:
//   Input channel (i_valid / o_ready, i_rx_byte) takes one received serial byte
//   per request. While hunting, bytes other than the start byte are dropped.
//   From the start byte on, FRAME_BYTES bytes are written to the frame RAM,
//   one per cycle, with o_ready held high.
//   After the last byte of a frame o_ready drops while the sequencer works
//   through the frame RAM over its single read port: the magic and length
//   checks, summing of bytes 0 to L+1, fetching and comparing the checksum
//   word, then reading each measurement word, high byte then low byte.
//   Output channel (o_valid / i_ready) carries word_index, word_value, status
//   and last from an output register. A good frame gives 12 requests, last on
//   the twelfth; a bad frame gives one request with its status and last set.
//   If the receiver stalls, the output register holds and the sequencer waits
//   with the next word; no result is dropped.
//   Reset (synchronous, active low) returns the block to hunting with the
//   output register empty. The frame RAM needs no clearing: every byte is
//   written in a frame before that frame reads it.
module sensor_frame_deframer
    import sfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int AW = $clog2(FRAME_BYTES);

    // sequencer states
    localparam logic [3:0] S_COLLECT = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_CKHI    = 4'd3;
    localparam logic [3:0] S_CKLO    = 4'd4;
    localparam logic [3:0] S_CMP     = 4'd5;
    localparam logic [3:0] S_ERR     = 4'd6;
    localparam logic [3:0] S_WHI     = 4'd7;
    localparam logic [3:0] S_WLO     = 4'd8;
    localparam logic [3:0] S_WOUT    = 4'd9;

    logic [3:0]    r_state, n_state;
    logic          r_collecting, n_collecting;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_byte1, n_byte1;
    logic [15:0]   r_len, n_len;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_end, n_end;
    logic [15:0]   r_sum, n_sum;
    logic          r_pend, n_pend;
    logic [7:0]    r_hi, n_hi;
    logic [1:0]    r_err, n_err;
    logic [3:0]    r_k, n_k;

    logic          r_o_valid, n_o_valid;
    logic [3:0]    r_o_index, n_o_index;
    logic [15:0]   r_o_value, n_o_value;
    logic [1:0]    r_o_status, n_o_status;
    logic          r_o_last, n_o_last;

    logic          in_acc;
    logic          out_free;
    logic [AW-1:0] wr_idx;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic [16:0]   len_need;

    assign o_ready  = (r_state == S_COLLECT);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign wr_idx   = r_collecting ? r_cnt : '0;
    assign ram_we   = in_acc && (r_collecting || (i_rx_byte == START_BYTE));
    assign ram_re   = (r_state == S_SUM) || (r_state == S_CKHI) || (r_state == S_CKLO)
                   || (r_state == S_WHI) || (r_state == S_WLO);
    assign len_need = {1'b0, r_len} + 17'(LEN_OVERHEAD);

    sfd_frame_ram #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // next-state logic for collection, checks and word emission
    always_comb begin
        n_state      = r_state;
        n_collecting = r_collecting;
        n_cnt        = r_cnt;
        n_byte1      = r_byte1;
        n_len        = r_len;
        n_ptr        = r_ptr;
        n_end        = r_end;
        n_sum        = r_sum;
        n_pend       = (r_state == S_SUM);
        n_hi         = r_hi;
        n_err        = r_err;
        n_k          = r_k;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_index    = r_o_index;
        n_o_value    = r_o_value;
        n_o_status   = r_o_status;
        n_o_last     = r_o_last;

        // sum bytes arrive in the cycle after their read
        if (r_pend) begin
            n_sum = r_sum + {8'd0, ram_rdata};
        end

        case (r_state)
            S_COLLECT: begin
                if (ram_we) begin
                    if (wr_idx == AW'(1)) n_byte1 = i_rx_byte;
                    if (wr_idx == AW'(2)) n_len[15:8] = i_rx_byte;
                    if (wr_idx == AW'(3)) n_len[7:0] = i_rx_byte;
                    if (wr_idx == AW'(FRAME_BYTES - 1)) begin
                        n_collecting = 1'b0;
                        n_cnt        = '0;
                        n_state      = S_CHECK;
                    end else begin
                        n_collecting = 1'b1;
                        n_cnt        = wr_idx + AW'(1);
                    end
                end
            end
            S_CHECK: begin
                if (r_byte1 != SECOND_MAGIC) begin
                    n_err   = ST_BAD_MAGIC;
                    n_state = S_ERR;
                end else if (len_need > 17'(FRAME_BYTES)) begin
                    n_err   = ST_BAD_LEN;
                    n_state = S_ERR;
                end else begin
                    n_ptr   = '0;
                    n_end   = r_len[AW-1:0] + AW'(1);
                    n_sum   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == r_end) begin
                    n_state = S_CKHI;
                end
            end
            S_CKHI: begin
                // read checksum high byte at L+2
                n_ptr   = r_ptr + AW'(1);
                n_state = S_CKLO;
            end
            S_CKLO: begin
                n_hi    = ram_rdata;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_sum != {r_hi, ram_rdata}) begin
                    n_err   = ST_BAD_SUM;
                    n_state = S_ERR;
                end else begin
                    n_ptr   = AW'(FIRST_WORD_OFFSET);
                    n_k     = '0;
                    n_state = S_WHI;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_index  = '0;
                    n_o_value  = '0;
                    n_o_status = r_err;
                    n_o_last   = 1'b1;
                    n_state    = S_COLLECT;
                end
            end
            S_WHI: begin
                n_ptr   = r_ptr + AW'(1);
                n_state = S_WLO;
            end
            S_WLO: begin
                n_hi    = ram_rdata;
                n_ptr   = r_ptr + AW'(1);
                n_state = S_WOUT;
            end
            S_WOUT: begin
                // low byte stays in the RAM read register until used
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_index  = r_k;
                    n_o_value  = {r_hi, ram_rdata};
                    n_o_status = ST_OK;
                    n_o_last   = (r_k == 4'(WORD_COUNT - 1));
                    if (r_k == 4'(WORD_COUNT - 1)) begin
                        n_state = S_COLLECT;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_WHI;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_COLLECT;
            r_collecting <= 1'b0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_pend       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_collecting <= n_collecting;
            r_cnt        <= n_cnt;
            r_sum        <= n_sum;
            r_pend       <= n_pend;
            r_o_valid    <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte1    <= n_byte1;
        r_len      <= n_len;
        r_ptr      <= n_ptr;
        r_end      <= n_end;
        r_hi       <= n_hi;
        r_err      <= n_err;
        r_k        <= n_k;
        r_o_index  <= n_o_index;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_word_index = r_o_index;
    assign o_word_value = r_o_value;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

`ifndef SYNTHESIS
    // error results are single, zero-valued and last
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
            (o_last && (o_word_index == 4'd0) && (o_word_value == 16'd0)))
        else $error("error result not a single zero last request");

    // good words carry last only on the final index
    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |->
            (o_last == (o_word_index == 4'(WORD_COUNT - 1))))
        else $error("last flag out of place on measurement word");

    // summing never runs past the checksum range
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_ptr <= r_end))
        else $error("sum pointer past end of checksum range");

    // no byte is taken while the sequencer owns the frame RAM
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_COLLECT) && !ram_re)
        else $error("frame RAM written while sequencer active");
`endif

endmodule
